// ===== rtl/msjk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stream JKISS32 generator package
// Shared types, command codes and constants for the generator block.
// ----------------------------------------------------------------------------
package msjk_pkg;

    localparam int STREAMS = 8;
    localparam int STREAM_AW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

    localparam logic [31:0] WEYL_STEP = 32'd1411392427;
    localparam logic [31:0] SEED_MULT = 32'd1812433253;

    localparam logic       CMD_SEED = 1'b0;
    localparam logic       CMD_DRAW = 1'b1;

    localparam logic [2:0] SEED_FIRST = 3'd1;
    localparam logic [2:0] SEED_LAST  = 3'd4;

    typedef struct packed {
        logic [31:0] weyl;
        logic [31:0] xs;
        logic [31:0] prev;
        logic [31:0] cur;
        logic [31:0] carry;
    } msjk_state_t;

    localparam int STATE_W = $bits(msjk_state_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP,
        ST_WORD,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_WRITE,
        ST_FLUSH
    } msjk_fsm_t;

endpackage

// ===== rtl/msjk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module msjk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/msjk_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JKISS32 step unit
// Advances one stream state by a single xorshift, add-with-carry and Weyl step.
// ----------------------------------------------------------------------------
module msjk_step (
    input  msjk_pkg::msjk_state_t st_in,
    output msjk_pkg::msjk_state_t st_out
);

    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] sum;

    always_comb begin
        x0  = st_in.xs ^ (st_in.xs << 5);
        x1  = x0 ^ (x0 >> 7);
        x2  = x1 ^ (x1 << 22);
        sum = st_in.prev + st_in.cur + st_in.carry;

        st_out.xs    = x2;
        st_out.prev  = st_in.cur;
        st_out.carry = {31'd0, sum[31]};
        st_out.cur   = {1'b0, sum[30:0]};
        st_out.weyl  = st_in.weyl + msjk_pkg::WEYL_STEP;
    end

endmodule

// ===== rtl/msjk_seed_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed multiplier
// Registered product of the seed multiplier and the folded previous word.
// ----------------------------------------------------------------------------
module msjk_seed_mul (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] word_in,
    output logic [31:0] prod
);

    logic [31:0] folded;
    logic [31:0] prod_reg;
    logic [31:0] prod_next;

    always_comb begin
        folded    = word_in ^ (word_in >> 30);
        prod_next = en ? (msjk_pkg::SEED_MULT * folded) : prod_reg;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/multi_stream_jkiss32_rng_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stream JKISS32 random generator
// Seeds and draws from independent JKISS32 streams held in one state RAM.
// ----------------------------------------------------------------------------
// A draw item runs a RAM read, then a step and a word state per draw, with a second
// draw in double mode, then write-back and output. A seed runs four multiply and add
// passes, each a multiply state and then an add state, followed by write-back.
// The next item is accepted only once the block has returned to idle.
// A result held off by m_tready stalls the block; s_tready is high only while idle.
// Reset clears the control state and double mode; stream words are undefined.
module multi_stream_jkiss32_rng_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // stream [2:0], seed_value [34:3], zero pad
    input  logic        s_tuser,   // command [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // random_word [31:0], fraction [83:32], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    msjk_pkg::msjk_fsm_t   state_reg, state_next;
    msjk_pkg::msjk_state_t wk_reg, wk_next;
    msjk_pkg::msjk_state_t step_out;

    logic [msjk_pkg::STREAM_AW-1:0] stream_reg, stream_next;
    logic [msjk_pkg::STREAM_AW-1:0] ram_raddr;
    logic [msjk_pkg::STATE_W-1:0]   ram_rdata;
    logic        ram_we;
    logic        cmd_reg, cmd_next;
    logic [2:0]  j_reg, j_next;
    logic        second_reg, second_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] res_word_reg, res_word_next;
    logic [51:0] res_frac_reg, res_frac_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_word_reg, m_word_next;
    logic [51:0] m_frac_reg, m_frac_next;
    logic        dbl_reg;
    logic        mul_en;
    logic [31:0] prod;
    logic [31:0] word;
    logic [63:0] pair;
    logic        in_range;
    logic [2:0]  s_stream;

    assign s_stream  = s_tdata[2:0];
    assign in_range  = 32'(s_stream) < 32'(msjk_pkg::STREAMS);
    assign ram_raddr = (state_reg == msjk_pkg::ST_IDLE)
                     ? msjk_pkg::STREAM_AW'(s_stream) : stream_reg;
    assign word      = wk_reg.weyl + wk_reg.xs + wk_reg.cur;
    assign pair      = {word, lo_reg};

    msjk_ram #(
        .WIDTH (msjk_pkg::STATE_W),
        .DEPTH (msjk_pkg::STREAMS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (stream_reg),
        .wdata (wk_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    msjk_step u_step (
        .st_in  (wk_reg),
        .st_out (step_out)
    );

    msjk_seed_mul u_mul (
        .aclk    (aclk),
        .en      (mul_en),
        .word_in (wk_reg.carry),
        .prod    (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= msjk_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            dbl_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                dbl_reg <= cfg_data;
            end
        end
        wk_reg       <= wk_next;
        stream_reg   <= stream_next;
        cmd_reg      <= cmd_next;
        j_reg        <= j_next;
        second_reg   <= second_next;
        lo_reg       <= lo_next;
        res_word_reg <= res_word_next;
        res_frac_reg <= res_frac_next;
        m_word_reg   <= m_word_next;
        m_frac_reg   <= m_frac_next;
    end

    always_comb begin
        state_next    = state_reg;
        wk_next       = wk_reg;
        stream_next   = stream_reg;
        cmd_next      = cmd_reg;
        j_next        = j_reg;
        second_next   = second_reg;
        lo_next       = lo_reg;
        res_word_next = res_word_reg;
        res_frac_next = res_frac_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_word_next   = m_word_reg;
        m_frac_next   = m_frac_reg;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        mul_en        = 1'b0;

        unique case (state_reg)
            msjk_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && in_range) begin
                    cmd_next    = s_tuser;
                    stream_next = msjk_pkg::STREAM_AW'(s_stream);
                    second_next = 1'b0;
                    if (s_tuser == msjk_pkg::CMD_DRAW) begin
                        state_next = msjk_pkg::ST_READ;
                    end else begin
                        wk_next.carry = s_tdata[34:3];
                        j_next        = msjk_pkg::SEED_FIRST;
                        state_next    = msjk_pkg::ST_SEED_MUL;
                    end
                end
            end
            msjk_pkg::ST_READ: begin
                wk_next    = msjk_pkg::msjk_state_t'(ram_rdata);
                state_next = msjk_pkg::ST_STEP;
            end
            msjk_pkg::ST_STEP: begin
                wk_next    = step_out;
                state_next = msjk_pkg::ST_WORD;
            end
            msjk_pkg::ST_WORD: begin
                if (dbl_reg && !second_reg) begin
                    lo_next     = word;
                    second_next = 1'b1;
                    state_next  = msjk_pkg::ST_STEP;
                end else begin
                    res_word_next = word;
                    res_frac_next = dbl_reg ? pair[63:12] : {word, 20'd0};
                    state_next    = msjk_pkg::ST_WRITE;
                end
            end
            msjk_pkg::ST_SEED_MUL: begin
                mul_en     = 1'b1;
                state_next = msjk_pkg::ST_SEED_ADD;
            end
            msjk_pkg::ST_SEED_ADD: begin
                wk_next.weyl  = wk_reg.xs;
                wk_next.xs    = wk_reg.prev;
                wk_next.prev  = wk_reg.cur;
                wk_next.cur   = wk_reg.carry;
                wk_next.carry = prod + 32'(j_reg);
                if (j_reg == msjk_pkg::SEED_LAST) begin
                    state_next = msjk_pkg::ST_WRITE;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = msjk_pkg::ST_SEED_MUL;
                end
            end
            msjk_pkg::ST_WRITE: begin
                ram_we     = 1'b1;
                state_next = (cmd_reg == msjk_pkg::CMD_DRAW)
                           ? msjk_pkg::ST_FLUSH : msjk_pkg::ST_IDLE;
            end
            msjk_pkg::ST_FLUSH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_word_next  = res_word_reg;
                    m_frac_next  = res_frac_reg;
                    state_next   = msjk_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = msjk_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'd0, m_frac_reg, m_word_reg};
    assign cfg_ready = 1'b1;

    a_read_then_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == msjk_pkg::ST_READ |=> state_reg == msjk_pkg::ST_STEP)
        else $error("RAM read not followed by a step");

    a_single_frac: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !dbl_reg |-> m_frac_reg[19:0] == 20'd0)
        else $error("Single-mode fraction has nonzero low bits");

    a_result_from_draw: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == msjk_pkg::ST_FLUSH
                            && $past(cmd_reg) == msjk_pkg::CMD_DRAW)
        else $error("Result item raised outside a draw");

    a_seed_index: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == msjk_pkg::ST_SEED_MUL |-> j_reg >= msjk_pkg::SEED_FIRST
                                            && j_reg <= msjk_pkg::SEED_LAST)
        else $error("Seed index out of range");

    a_awc_31bit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == msjk_pkg::ST_STEP |=> !wk_reg.cur[31])
        else $error("Add-with-carry word exceeds 31 bits");

endmodule
